// ===== src/frd_pkg.sv =====
// Shared types and constants for the firmware record deframer.
`timescale 1ns / 1ps

package frd_pkg;

    // Configuration port widths and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_LEN = 2'd2;

    // Register values after reset
    localparam logic [19:0] RST_IMAGE_OFFSET   = 20'd0;
    localparam logic [5:0]  RST_CHUNK_LEN      = 6'd50;
    localparam logic [15:0] RST_MAX_RECORD_LEN = 16'd1023;

    // Record length that ends the load with success
    localparam logic [15:0] LEN_TERMINATOR = 16'h8001;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BADLEN = 2'd2,
        KIND_TRUNC  = 2'd3
    } t_kind;

    // One image byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } t_in_item;

    // One result
    typedef struct packed {
        t_kind       kind;
        logic [15:0] load_address;
        logic [7:0]  payload_byte;
        logic        chunk_end;
        logic        record_end;
        logic        last;
    } t_out_item;

    // Configuration registers as seen by the parser
    typedef struct packed {
        logic [19:0] image_offset;
        logic [5:0]  chunk_len;
        logic [15:0] max_record_len;
    } t_cfg;

    // Results produced by one parse step, written to the result queue
    typedef struct packed {
        logic      wr0;
        logic      wr1;
        t_out_item r0;
        t_out_item r1;
    } t_step;

endpackage

// ===== src/firmware_record_deframer_core.sv =====
// Top level of the firmware record deframer: input register, configuration and result queue.
//
// Image bytes enter on i_valid/i_data, one transfer per byte; o_stall holds them back.
// Results leave on o_valid/o_data, one transfer per result; i_stall holds them back.
// Each byte gives zero, one or two results; o_data.last marks the last one of a byte.
// Configuration registers are written on i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data; o_cfg_ready is always high and a write takes effect on the next byte.
// A byte is taken into the input register and parsed once the queue has room; its
// results are written to the result queue and are readable there in the next cycle.
// The sustained rate is one byte per cycle while each byte gives at most one result and
// the receiver does not stall; the result channel moves one result per cycle, so a byte
// with two results takes two transfers. The parse step waits until the queue has room
// for two results. When the receiver stalls, the queue fills and o_stall rises once
// the input register is occupied and cannot be parsed. Reset (i_rst_n low, synchronous)
// empties the input register and the queue, returns the parser to offset skipping with
// cleared state, and loads the registers with offset 0, chunk length 50, and a record
// limit of 1023.
`timescale 1ns / 1ps

module firmware_record_deframer_core #(
    parameter int RESQ_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  frd_pkg::t_in_item                i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output frd_pkg::t_out_item               o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [frd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [frd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import frd_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;
    t_cfg     r_cfg;
    logic     room;
    logic     consume;
    t_step    step;

    assign o_cfg_ready = 1'b1;
    assign consume     = r_in_valid && room;
    assign o_stall     = r_in_valid && !consume;

    // Input register, refilled whenever its byte is parsed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_item <= i_data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_offset   <= RST_IMAGE_OFFSET;
            r_cfg.chunk_len      <= RST_CHUNK_LEN;
            r_cfg.max_record_len <= RST_MAX_RECORD_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_OFFSET:   r_cfg.image_offset   <= i_cfg_data[19:0];
                CFG_CHUNK_LEN:      r_cfg.chunk_len      <= i_cfg_data[5:0];
                CFG_MAX_RECORD_LEN: r_cfg.max_record_len <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Parser and result queue
    frd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_item    (r_in_item),
        .i_cfg     (r_cfg),
        .o_step    (step)
    );

    frd_resq #(
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // The queue comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result queue not empty after reset");

    // A second result of a byte never comes without a first one.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.wr1 |-> step.wr0)
        else $error("second result written without a first");

    // A written result is offered in the next cycle.
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.wr0 |=> o_valid)
        else $error("written result not offered");

    // A byte waiting for queue room keeps its value.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_item))
        else $error("waiting input byte changed");

endmodule

// ===== src/frd_parse.sv =====
// Record parser: holds the deframing state and turns one image byte into up to two results.
`timescale 1ns / 1ps

module frd_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_consume,
    input  frd_pkg::t_in_item i_item,
    input  frd_pkg::t_cfg   i_cfg,
    output frd_pkg::t_step  o_step
);
    import frd_pkg::*;

    typedef enum logic [3:0] {
        PH_SKIP    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [19:0] r_skip_count,   n_skip_count;
    logic [1:0]  r_header_index, n_header_index;
    logic [23:0] r_header_bytes, n_header_bytes;
    logic [15:0] r_bytes_left,   n_bytes_left;
    logic [15:0] r_next_address, n_next_address;
    logic [5:0]  r_chunk_fill,   n_chunk_fill;

    logic        skip_lt;
    logic        eoi;
    logic        enter_hdr;
    logic        do_hdr;
    logic [1:0]  cur_idx;
    logic [23:0] cur_bytes;
    logic [15:0] rec_len;
    logic [15:0] rec_addr;
    logic [5:0]  fill;
    logic [15:0] left;
    logic        rend;
    logic        cend;
    t_step       step;

    assign skip_lt   = r_skip_count < i_cfg.image_offset;
    assign eoi       = i_item.end_of_image;
    // Offset done: this byte is already the first header byte.
    assign enter_hdr = (r_phase == PH_SKIP) && !skip_lt;
    assign do_hdr    = enter_hdr || ((r_phase == PH_HEADER) && !(skip_lt && eoi));
    assign cur_idx   = enter_hdr ? 2'd0 : r_header_index;
    assign cur_bytes = enter_hdr ? 24'd0 : r_header_bytes;
    assign rec_len   = cur_bytes[23:8];
    assign rec_addr  = {cur_bytes[7:0], i_item.data_byte};
    assign fill      = r_chunk_fill + 6'd1;
    assign left      = r_bytes_left - 16'd1;
    assign rend      = (left == 16'd0);
    assign cend      = (fill == i_cfg.chunk_len) || rend;

    // Next state and results for the byte being consumed
    always_comb begin
        n_phase        = r_phase;
        n_skip_count   = r_skip_count;
        n_header_index = r_header_index;
        n_header_bytes = r_header_bytes;
        n_bytes_left   = r_bytes_left;
        n_next_address = r_next_address;
        n_chunk_fill   = r_chunk_fill;
        step           = '0;

        if (i_consume) begin
            if (do_hdr) begin
                n_phase = PH_HEADER;
                if (cur_idx != 2'd3) begin
                    n_header_bytes = {cur_bytes[15:0], i_item.data_byte};
                    n_header_index = cur_idx + 2'd1;
                end else begin
                    n_header_index = 2'd0;
                    n_header_bytes = 24'd0;
                    if (rec_len == LEN_TERMINATOR) begin
                        step.wr0     = 1'b1;
                        step.r0.kind = KIND_DONE;
                        n_phase      = PH_HALT;
                    end else if (rec_len == 16'd0) begin
                        n_phase = PH_HEADER;
                    end else if (rec_len > i_cfg.max_record_len) begin
                        step.wr0     = 1'b1;
                        step.r0.kind = KIND_BADLEN;
                        n_phase      = PH_HALT;
                    end else begin
                        n_bytes_left   = rec_len;
                        n_next_address = rec_addr;
                        n_chunk_fill   = 6'd0;
                        n_phase        = PH_PAYLOAD;
                    end
                end
                // Image ended inside a header or between records.
                if (eoi && (n_phase != PH_HALT)) begin
                    step.wr0     = 1'b1;
                    step.r0.kind = KIND_TRUNC;
                end
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_skip_count = r_skip_count + 20'd1;
                        if (eoi) begin
                            step.wr0     = 1'b1;
                            step.r0.kind = KIND_TRUNC;
                        end
                    end
                    PH_PAYLOAD: begin
                        step.wr0             = 1'b1;
                        step.r0.kind         = KIND_DATA;
                        step.r0.load_address = r_next_address;
                        step.r0.payload_byte = i_item.data_byte;
                        step.r0.chunk_end    = cend;
                        step.r0.record_end   = rend;
                        n_bytes_left         = left;
                        n_next_address       = r_next_address + 16'd1;
                        n_chunk_fill         = cend ? 6'd0 : fill;
                        if (rend) begin
                            n_phase        = PH_HEADER;
                            n_header_index = 2'd0;
                            n_header_bytes = 24'd0;
                        end
                        if (eoi) begin
                            step.wr1     = 1'b1;
                            step.r1.kind = KIND_TRUNC;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // The last result of this byte carries the last flag.
            if (step.wr1) begin
                step.r1.last = 1'b1;
            end else begin
                step.r0.last = step.wr0;
            end

            // End of image re-arms the parser for the next image.
            if (eoi) begin
                n_phase        = PH_SKIP;
                n_skip_count   = 20'd0;
                n_header_index = 2'd0;
                n_header_bytes = 24'd0;
                n_bytes_left   = 16'd0;
                n_next_address = 16'd0;
                n_chunk_fill   = 6'd0;
            end
        end
    end

    assign o_step = step;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SKIP;
            r_skip_count   <= 20'd0;
            r_header_index <= 2'd0;
            r_header_bytes <= 24'd0;
            r_bytes_left   <= 16'd0;
            r_next_address <= 16'd0;
            r_chunk_fill   <= 6'd0;
        end else begin
            r_phase        <= n_phase;
            r_skip_count   <= n_skip_count;
            r_header_index <= n_header_index;
            r_header_bytes <= n_header_bytes;
            r_bytes_left   <= n_bytes_left;
            r_next_address <= n_next_address;
            r_chunk_fill   <= n_chunk_fill;
        end
    end

endmodule

// ===== src/frd_resq.sv =====
// Result queue: takes up to two results per cycle and hands out one result per transfer.
`timescale 1ns / 1ps

module frd_resq #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frd_pkg::t_step     i_step,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output frd_pkg::t_out_item o_data
);
    import frd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    t_out_item     r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] wr_ptr1;
    logic [AW-1:0] wr_ptr2;
    logic          pop;

    // Pointer arithmetic with wrap at the queue depth
    assign wr_ptr1 = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
    assign wr_ptr2 = (wr_ptr1 == LAST_IDX) ? '0 : wr_ptr1 + 1'b1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= ROOM_MAX);
    assign pop     = o_valid && !i_stall;

    // Next pointer and fill values
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_step.wr1) begin
            n_wr_ptr = wr_ptr2;
        end else if (i_step.wr0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_count = r_count + CW'(i_step.wr0) + CW'(i_step.wr1) - CW'(pop);
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_step.wr0) begin
            r_mem[r_wr_ptr] <= i_step.r0;
        end
        if (i_step.wr1) begin
            r_mem[wr_ptr1] <= i_step.r1;
        end
    end

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== tb/sv/frd_load_checker.sv =====
// Checker for the record deframer: tracks parse state, predicts load results and compares them.
`timescale 1ns / 1ps

module frd_load_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  frd_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  frd_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [frd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [frd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    import frd_pkg::*;

    // Parser phases of the local model.
    typedef enum logic [1:0] {
        ST_SEEK   = 2'd0,
        ST_HEADER = 2'd1,
        ST_COPY   = 2'd2,
        ST_HALT   = 2'd3
    } t_walk;

    // Register copies, updated on every configuration transfer.
    logic [19:0] cfg_offset;
    logic [5:0]  cfg_chunk;
    logic [15:0] cfg_max;

    // Parse state of the local model.
    t_walk       phase;
    logic [19:0] skip_count;
    logic [1:0]  header_index;
    logic [23:0] header_bytes;
    logic [15:0] bytes_left;
    logic [15:0] next_address;
    logic [5:0]  chunk_fill;

    // Load results predicted but not yet seen on the output channel, oldest first.
    t_out_item load_stream [$];

    task automatic clear_walk();
        phase        = ST_SEEK;
        skip_count   = '0;
        header_index = '0;
        header_bytes = '0;
        bytes_left   = '0;
        next_address = '0;
        chunk_fill   = '0;
    endtask

    function automatic t_out_item load_result(input t_kind kind, input logic [15:0] addr,
                                              input logic [7:0] data, input logic ce,
                                              input logic re);
        t_out_item r;
        r.kind         = kind;
        r.load_address = addr;
        r.payload_byte = data;
        r.chunk_end    = ce;
        r.record_end   = re;
        r.last         = 1'b0;
        return r;
    endfunction

    // Advance the model by one image byte and queue the results it causes.
    task automatic deframe_byte(input logic [7:0] data, input logic eoi);
        t_out_item   res [2];
        int          n;
        logic [5:0]  fill;
        logic [15:0] len;
        logic [15:0] addr;
        logic        rec_end;
        logic        chk_end;
        n = 0;

        // Leading bytes of the image are dropped until the offset is reached.
        if (phase == ST_SEEK) begin
            if (skip_count < cfg_offset) begin
                skip_count = skip_count + 20'd1;
                if (eoi) begin
                    res[n] = load_result(KIND_TRUNC, '0, '0, 1'b0, 1'b0);
                    n++;
                end
            end else begin
                phase        = ST_HEADER;
                header_index = '0;
                header_bytes = '0;
            end
        end

        if (n == 0 && phase == ST_HEADER && !(skip_count < cfg_offset && eoi)) begin
            // Collect three header bytes; the fourth completes the header.
            if (header_index < 2'd3) begin
                header_bytes = {header_bytes[15:0], data};
                header_index = header_index + 2'd1;
            end else begin
                len          = header_bytes[23:8];
                addr         = {header_bytes[7:0], data};
                header_index = '0;
                header_bytes = '0;
                if (len == LEN_TERMINATOR) begin
                    res[n] = load_result(KIND_DONE, '0, '0, 1'b0, 1'b0);
                    n++;
                    phase = ST_HALT;
                end else if (len != 16'd0) begin
                    if (len > cfg_max) begin
                        res[n] = load_result(KIND_BADLEN, '0, '0, 1'b0, 1'b0);
                        n++;
                        phase = ST_HALT;
                    end else begin
                        bytes_left   = len;
                        next_address = addr;
                        chunk_fill   = '0;
                        phase        = ST_COPY;
                    end
                end
            end
            if (eoi && phase != ST_HALT) begin
                res[n] = load_result(KIND_TRUNC, '0, '0, 1'b0, 1'b0);
                n++;
            end
        end else if (phase == ST_COPY) begin
            // Payload byte: emit it with its address and the chunk and record marks.
            fill       = chunk_fill + 6'd1;
            bytes_left = bytes_left - 16'd1;
            rec_end    = (bytes_left == 16'd0);
            chk_end    = (fill == cfg_chunk) || rec_end;
            res[n]     = load_result(KIND_DATA, next_address, data, chk_end, rec_end);
            n++;
            next_address = next_address + 16'd1;
            chunk_fill   = chk_end ? 6'd0 : fill;
            if (rec_end) begin
                phase        = ST_HEADER;
                header_index = '0;
                header_bytes = '0;
            end
            if (eoi) begin
                res[n] = load_result(KIND_TRUNC, '0, '0, 1'b0, 1'b0);
                n++;
            end
        end

        // The end of an image always re-arms the parser.
        if (eoi) begin
            clear_walk();
        end
        for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            load_stream.push_back(res[k]);
        end
    endtask

    // Watch all three channels at each clock edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_offset = RST_IMAGE_OFFSET;
            cfg_chunk  = RST_CHUNK_LEN;
            cfg_max    = RST_MAX_RECORD_LEN;
            clear_walk();
            load_stream.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_OFFSET:   cfg_offset = i_cfg_data[19:0];
                    CFG_CHUNK_LEN:      cfg_chunk  = i_cfg_data[5:0];
                    CFG_MAX_RECORD_LEN: cfg_max    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_in_data.data_byte, i_in_data.end_of_image);
            end
            // Compare each result transfer with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (load_stream.size() == 0) begin
                    $error("unexpected result: kind %0d address %h byte %h",
                           i_out_data.kind, i_out_data.load_address,
                           i_out_data.payload_byte);
                    o_fail_count++;
                end else begin
                    want = load_stream.pop_front();
                    if (i_out_data.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out_data.kind);
                        o_fail_count++;
                    end
                    if (i_out_data.load_address !== want.load_address) begin
                        $error("load_address: expected %h, got %h",
                               want.load_address, i_out_data.load_address);
                        o_fail_count++;
                    end
                    if (i_out_data.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %h, got %h",
                               want.payload_byte, i_out_data.payload_byte);
                        o_fail_count++;
                    end
                    if (i_out_data.chunk_end !== want.chunk_end) begin
                        $error("chunk_end: expected %0b, got %0b",
                               want.chunk_end, i_out_data.chunk_end);
                        o_fail_count++;
                    end
                    if (i_out_data.record_end !== want.record_end) begin
                        $error("record_end: expected %0b, got %0b",
                               want.record_end, i_out_data.record_end);
                        o_fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out_data.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = load_stream.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the record deframer testbench: clock, reset, image stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;

    import frd_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_ITEMS = 550;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int stall_hold  = 0;
    int idle_pct    = 0;

    // Register values the image generator works with.
    logic [19:0] cur_offset = RST_IMAGE_OFFSET;
    logic [15:0] cur_max    = RST_MAX_RECORD_LEN;

    // Bytes of the image being built, in file order.
    logic [7:0] image_q [$];

    firmware_record_deframer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    frd_load_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Receiver stalls come in random bursts of random length.
    always @(posedge clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 399) < idle_pct) begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 16);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("firmware_record_deframer_core test failed");
            $finish;
        end
    end

    // Offer one image byte, possibly after a gap, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_data.data_byte     <= b;
        in_data.end_of_image  <= eoi;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_image();
        for (int k = 0; k < image_q.size(); k++) begin
            send_byte(image_q[k], k == image_q.size() - 1);
        end
        image_q.delete();
    endtask

    // Wait until every predicted result has been seen, plus the pipeline latency.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [19:0] offset, input logic [5:0] clen,
                            input logic [15:0] maxlen);
        write_reg(CFG_IMAGE_OFFSET, offset);
        write_reg(CFG_CHUNK_LEN, CFG_DATA_W'(clen));
        write_reg(CFG_MAX_RECORD_LEN, CFG_DATA_W'(maxlen));
        cfg_valid  <= 1'b0;
        cur_offset = offset;
        cur_max    = maxlen;
    endtask

    task automatic add_header(input logic [15:0] len, input logic [15:0] addr);
        image_q.push_back(len[15:8]);
        image_q.push_back(len[7:0]);
        image_q.push_back(addr[15:8]);
        image_q.push_back(addr[7:0]);
    endtask

    task automatic add_random_bytes(input int count);
        logic [7:0] rb;
        for (int k = 0; k < count; k++) begin
            rb = 8'($urandom);
            image_q.push_back(rb);
        end
    endtask

    // Build one random image; mostly well-formed records with a random ending.
    task automatic build_image(output int parsed_bytes);
        int          style;
        int          nrec;
        int          lim;
        int          ending;
        int          cut;
        logic [15:0] len;
        logic [15:0] addr;
        style = $urandom_range(0, 99);
        if (style < 8) begin
            // Pure noise, ending somewhere random.
            add_random_bytes($urandom_range(1, 12));
            parsed_bytes = image_q.size();
        end else begin
            add_random_bytes(int'(cur_offset));
            nrec = $urandom_range(0, 4);
            for (int r = 0; r < nrec; r++) begin
                addr = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    addr = 16'hFFFF - 16'($urandom_range(0, 10));
                end
                if ($urandom_range(0, 9) == 0 || cur_max == 16'd0) begin
                    add_header(16'd0, addr);
                end else begin
                    lim = (cur_max < 16'd70) ? int'(cur_max) : 70;
                    if ($urandom_range(0, 19) == 0 && cur_max >= 16'd130) begin
                        lim = 130;
                    end
                    len = 16'($urandom_range(1, lim));
                    add_header(len, addr);
                    add_random_bytes(int'(len));
                end
            end
            addr   = 16'($urandom);
            ending = $urandom_range(0, 9);
            if (ending == 6 && cur_max != 16'hFFFF) begin
                // Record length over the limit.
                len = 16'($urandom_range(int'(cur_max) + 1, 65535));
                if (len == LEN_TERMINATOR) begin
                    len = len + 16'd1;
                end
                add_header(len, addr);
                add_random_bytes($urandom_range(0, 3));
            end else if (ending == 7) begin
                // No terminator: the image ends after its records.
                if (image_q.size() == 0) begin
                    add_random_bytes(1);
                end
            end else begin
                add_header(LEN_TERMINATOR, addr);
                if (ending >= 8) begin
                    // Cut the image short somewhere inside it.
                    cut = $urandom_range(1, image_q.size());
                    while (image_q.size() > cut) begin
                        void'(image_q.pop_back());
                    end
                end else begin
                    add_random_bytes($urandom_range(0, 3));
                end
            end
            parsed_bytes = (image_q.size() > int'(cur_offset)) ?
                           image_q.size() - int'(cur_offset) : 0;
        end
    endtask

    // Main stimulus sequence.
    initial begin
        int          parsed;
        int          total;
        int          img;
        int          setting;
        logic [19:0] offset;
        logic [5:0]  clen;
        logic [15:0] maxlen;
        repeat (6) @(posedge clk);
        rst_n    <= 1'b1;
        idle_pct = 20;

        // Address wrap, a zero-length record, then the terminator.
        add_header(16'h0002, 16'hFFFF);
        image_q.push_back(8'h00);
        image_q.push_back(8'hFF);
        add_header(16'h0000, 16'h1234);
        add_header(LEN_TERMINATOR, 16'h0000);
        send_image();
        // Length one above the reset limit.
        add_header(16'h0400, 16'h8000);
        send_image();
        // Image ending on a payload byte.
        add_header(16'h0003, 16'h00AA);
        image_q.push_back(8'h5A);
        image_q.push_back(8'hA5);
        send_image();
        // Largest offset, with the image ending while still skipping.
        drain();
        set_regs(20'hFFFFF, 6'd63, 16'd0);
        add_random_bytes(3);
        send_image();

        total = 0;
        img   = 0;
        while (total < RANDOM_ITEMS) begin
            if (img % 6 == 0) begin
                drain();
                setting = img / 6;
                case (setting)
                    0: begin offset = 20'd0; clen = 6'd1;  maxlen = 16'hFFFF; end
                    1: begin offset = 20'd3; clen = 6'd0;  maxlen = 16'd100;  end
                    2: begin offset = 20'd1; clen = 6'd63; maxlen = 16'd1;    end
                    3: begin offset = 20'd0; clen = 6'd7;  maxlen = 16'd0;    end
                    default: begin
                        offset = ($urandom_range(0, 2) == 0) ?
                                 20'($urandom_range(1, 7)) : 20'd0;
                        clen   = 6'($urandom_range(0, 63));
                        case ($urandom_range(0, 5))
                            0:       maxlen = 16'hFFFF;
                            1:       maxlen = RST_MAX_RECORD_LEN;
                            2:       maxlen = 16'd1;
                            default: maxlen = 16'($urandom_range(2, 80));
                        endcase
                    end
                endcase
                set_regs(offset, clen, maxlen);
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            // The tail of the run goes without any idling.
            if (total > RANDOM_ITEMS - 80) begin
                idle_pct = 0;
            end
            build_image(parsed);
            total = total + parsed;
            send_image();
            img++;
        end
        drain();

        if (fail_count == 0) begin
            $display("firmware_record_deframer_core test passed");
        end else begin
            $display("firmware_record_deframer_core test failed");
        end
        $finish;
    end

endmodule
